[sv/selective_repeat_reorder_receiver_top_defines.svh]
`ifndef SELECTIVE_REPEAT_REORDER_RECEIVER_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_REORDER_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, sampled on clk, off during reset
`define SRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[sv/srr_pkg.sv]
`timescale 1ns / 1ps

package srr_pkg;

    localparam int unsigned WINDOW_SLOTS_DEF = 16;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MAGIC_W  = 32;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 11'd1500;

    typedef enum logic {
        KIND_DELIVER = 1'b0,
        KIND_ACK     = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        CLS_IN_ORDER,
        CLS_EARLY,
        CLS_OLD
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACT,
        ST_DRAIN,
        ST_DRAIN_OUT,
        ST_ACK
    } back_state_t;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    len;
        logic                eof;
        logic [TIME_W-1:0]   stime;
        logic [HANDLE_W-1:0] handle;
    } item_t;

    typedef struct packed {
        kind_t               kind;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic [SEQ_W-1:0]    ack;
        logic                ack_eof;
        logic [TIME_W-1:0]   etime;
        logic                last;
    } result_t;

endpackage

[sv/srr_ram.sv]
`timescale 1ns / 1ps

module srr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/srr_front.sv]
`timescale 1ns / 1ps

module srr_front
    import srr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [MAGIC_W-1:0]  cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MAGIC_W-1:0]  magic_word,
    input  logic                checksum_ok,
    input  logic [SEQ_W-1:0]    sequence_req,
    input  logic [LEN_W-1:0]    payload_length,
    input  logic                end_of_file,
    input  logic [TIME_W-1:0]   send_time,
    input  logic [HANDLE_W-1:0] payload_handle,
    input  logic                q_full,
    output logic                q_push,
    output item_t               q_item
);

    logic [MAGIC_W-1:0] magic_reg;
    logic [MAGIC_W-1:0] magic_next;

    always_comb
    begin
        magic_next = magic_reg;
        if (cfg_wr_en)
        begin
            magic_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= '0;
        end
        else
        begin
            magic_reg <= magic_next;
        end
    end

    // foreign or corrupt words are consumed here and never reach the queue
    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready && checksum_ok && (magic_word == magic_reg);

    always_comb
    begin
        q_item.seq    = sequence_req;
        q_item.len    = (payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_length;
        q_item.eof    = end_of_file;
        q_item.stime  = send_time;
        q_item.handle = payload_handle;
    end

endmodule

[sv/srr_queue.sv]
`timescale 1ns / 1ps

module srr_queue
    import srr_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/srr_back.sv]
`timescale 1ns / 1ps

module srr_back
    import srr_pkg::*;
#(
    parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_res
);

    localparam int unsigned IDX_W  = $clog2(WINDOW_SLOTS);
    localparam int unsigned SLOT_W = LEN_W + HANDLE_W;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(WINDOW_SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_WIDE = (IDX_W + 1)'(WINDOW_SLOTS);
    localparam logic [SEQ_W-1:0] SLOTS_SEQ  = SEQ_W'(WINDOW_SLOTS);

    back_state_t              state_reg, state_next;
    cls_t                     cls_reg, cls_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [SEQ_W-1:0]         exp_reg, exp_next;
    logic [IDX_W-1:0]         exp_idx_reg, exp_idx_next;
    logic                     finished_reg, finished_next;
    logic [WINDOW_SLOTS-1:0]  slot_valid_reg, slot_valid_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_res_reg, out_res_next;

    logic                     out_free;
    logic                     load;
    logic                     seq_eq, seq_gt, in_window;
    logic [SEQ_W-1:0]         seq_gap;
    logic [IDX_W:0]           idx_sum;
    logic [IDX_W-1:0]         slot_idx;
    logic                     ram_we, ram_re;
    logic [SLOT_W-1:0]        ram_rdata;
    logic [LEN_W-1:0]         rd_len;
    logic [HANDLE_W-1:0]      rd_handle;

    srr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata ({q_item.len, q_item.handle}),
        .re    (ram_re),
        .raddr (exp_idx_reg),
        .rdata (ram_rdata)
    );

    assign {rd_len, rd_handle} = ram_rdata;

    // window arithmetic; seq is ahead by less than the window, so one wrap at most
    assign seq_eq    = (q_item.seq == exp_reg);
    assign seq_gt    = (q_item.seq > exp_reg);
    assign seq_gap   = q_item.seq - exp_reg;
    assign in_window = (seq_gap < SLOTS_SEQ);
    assign idx_sum   = {1'b0, exp_idx_reg} + {1'b0, seq_gap[IDX_W-1:0]};
    assign slot_idx  = (idx_sum >= SLOTS_WIDE) ? IDX_W'(idx_sum - SLOTS_WIDE)
                                               : idx_sum[IDX_W-1:0];

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        cls_next        = cls_reg;
        idx_next        = idx_reg;
        exp_next        = exp_reg;
        exp_idx_next    = exp_idx_reg;
        finished_next   = finished_reg;
        slot_valid_next = slot_valid_reg;
        out_res_next    = out_res_reg;
        load            = 1'b0;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (finished_reg || (seq_gt && !in_window))
                    begin
                        q_pop = 1'b1;
                    end
                    else
                    begin
                        priority if (seq_eq)
                        begin
                            cls_next = CLS_IN_ORDER;
                        end
                        else if (seq_gt)
                        begin
                            cls_next = CLS_EARLY;
                        end
                        else
                        begin
                            cls_next = CLS_OLD;
                        end
                        idx_next   = slot_idx;
                        state_next = ST_ACT;
                    end
                end
            end
            ST_ACT:
            begin
                unique case (cls_reg)
                    CLS_IN_ORDER:
                    begin
                        if (out_free)
                        begin
                            load         = 1'b1;
                            out_res_next = '{kind: KIND_DELIVER, handle: q_item.handle,
                                             len: q_item.len, ack: '0, ack_eof: 1'b0,
                                             etime: '0, last: 1'b0};
                            state_next   = ST_DRAIN;
                        end
                    end
                    CLS_EARLY:
                    begin
                        if (!slot_valid_reg[idx_reg] && (q_item.len != '0))
                        begin
                            ram_we                   = 1'b1;
                            slot_valid_next[idx_reg] = 1'b1;
                        end
                        state_next = ST_ACK;
                    end
                    CLS_OLD:
                    begin
                        state_next = ST_ACK;
                    end
                    default:
                    begin
                        state_next = ST_ACK;
                    end
                endcase
            end
            ST_DRAIN:
            begin
                if (slot_valid_reg[exp_idx_reg])
                begin
                    ram_re                       = 1'b1;
                    slot_valid_next[exp_idx_reg] = 1'b0;
                    state_next                   = ST_DRAIN_OUT;
                end
                else
                begin
                    state_next = ST_ACK;
                end
            end
            ST_DRAIN_OUT:
            begin
                if (out_free)
                begin
                    load         = 1'b1;
                    out_res_next = '{kind: KIND_DELIVER, handle: rd_handle, len: rd_len,
                                     ack: '0, ack_eof: 1'b0, etime: '0, last: 1'b0};
                    state_next   = ST_DRAIN;
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_res_next  = '{kind: KIND_ACK, handle: '0, len: '0,
                                      ack: exp_reg - 1'b1, ack_eof: q_item.eof,
                                      etime: q_item.stime, last: 1'b1};
                    finished_next = finished_reg || q_item.eof;
                    q_pop         = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // every delivery advances the expected number; index resets on 32-bit wrap
        if (load && (out_res_next.kind == KIND_DELIVER))
        begin
            exp_next = exp_reg + 1'b1;
            priority if (exp_reg == '1)
            begin
                exp_idx_next = '0;
            end
            else if (exp_idx_reg == LAST_IDX)
            begin
                exp_idx_next = '0;
            end
            else
            begin
                exp_idx_next = exp_idx_reg + 1'b1;
            end
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cls_reg        <= CLS_OLD;
            exp_reg        <= SEQ_W'(1);
            exp_idx_reg    <= IDX_W'(1);
            finished_reg   <= 1'b0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cls_reg        <= cls_next;
            exp_reg        <= exp_next;
            exp_idx_reg    <= exp_idx_next;
            finished_reg   <= finished_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

[sv/selective_repeat_reorder_receiver_top.sv]
// Path: an accepted word enters the queue, is classified in ST_IDLE and handled in ST_ACT;
// an in-order word then passes ST_DRAIN and ST_ACK, an early or old word goes to ST_ACK,
// and each buffered slot drained adds ST_DRAIN_OUT after the registered read of the slot RAM.
// Words failing the header checks are consumed by the front end; back-end drops pop in ST_IDLE.
// Reset: async active low; expected sequence 1, all slots empty, magic 0, queue empty.
// Slot handles are not cleared; slot valid flops cover them, so there is no clearing pass.
`timescale 1ns / 1ps

module selective_repeat_reorder_receiver_top
    import srr_pkg::*;
#(
    parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [MAGIC_W-1:0]  cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MAGIC_W-1:0]  magic_word,
    input  logic                checksum_ok,
    input  logic [SEQ_W-1:0]    sequence_req,
    input  logic [LEN_W-1:0]    payload_length,
    input  logic                end_of_file,
    input  logic [TIME_W-1:0]   send_time,
    input  logic [HANDLE_W-1:0] payload_handle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                result_kind,
    output logic [HANDLE_W-1:0] delivered_handle,
    output logic [LEN_W-1:0]    delivered_length,
    output logic [SEQ_W-1:0]    ack_number,
    output logic                ack_end_of_file,
    output logic [TIME_W-1:0]   echo_time,
    output logic                last_of_run
);

    logic    q_full;
    logic    q_push;
    item_t   q_push_item;
    logic    q_pop;
    logic    q_head_valid;
    item_t   q_head;
    result_t res;

    srr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .magic_word     (magic_word),
        .checksum_ok    (checksum_ok),
        .sequence_req   (sequence_req),
        .payload_length (payload_length),
        .end_of_file    (end_of_file),
        .send_time      (send_time),
        .payload_handle (payload_handle),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_push_item)
    );

    srr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    srr_back #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_head_valid),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (res)
    );

    assign result_kind      = res.kind;
    assign delivered_handle = res.handle;
    assign delivered_length = res.len;
    assign ack_number       = res.ack;
    assign ack_end_of_file  = res.ack_eof;
    assign echo_time        = res.etime;
    assign last_of_run      = res.last;

endmodule

[sv/srr_checker.sv]
`timescale 1ns / 1ps
`include "selective_repeat_reorder_receiver_top_defines.svh"

module srr_assertions
    import srr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic                result_kind,
    input logic [HANDLE_W-1:0] delivered_handle,
    input logic [LEN_W-1:0]    delivered_length,
    input logic [SEQ_W-1:0]    ack_number,
    input logic                ack_end_of_file,
    input logic [TIME_W-1:0]   echo_time,
    input logic                last_of_run
);

    `SRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(result_kind) && $stable(ack_number) && $stable(delivered_handle))
    `SRR_ASSERT_NOW(a_len_cap, out_valid && (result_kind == KIND_DELIVER),
        delivered_length <= MAX_PAYLOAD)
    `SRR_ASSERT_NOW(a_deliver_not_last, out_valid && (result_kind == KIND_DELIVER),
        !last_of_run && (ack_number == '0) && (echo_time == '0))
    `SRR_ASSERT_NEXT(a_eof_quiet,
        out_valid && out_ready && (result_kind == KIND_ACK) && ack_end_of_file, !out_valid)

endmodule

bind selective_repeat_reorder_receiver_top srr_assertions u_srr_assertions (.*);
